@@ rtl/tlx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlx_pkg
// Types, character codes and keyword tables shared by the token lexer.
// ----------------------------------------------------------------------------
package tlx_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_DIGITS  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_SLASH   = 3'd4,
        MODE_COMMENT = 3'd5
    } scan_mode_t;

    typedef enum logic [3:0] {
        KIND_ID     = 4'd0,
        KIND_INT    = 4'd1,
        KIND_STRING = 4'd2,
        KIND_PLUS   = 4'd3,
        KIND_MINUS  = 4'd4,
        KIND_STAR   = 4'd5,
        KIND_SLASH  = 4'd6,
        KIND_SET    = 4'd7,
        KIND_PRINT  = 4'd8,
        KIND_SEMI   = 4'd9,
        KIND_DONE   = 4'd10
    } token_kind_t;

    // One result: a token, or one character of the current lexeme.
    typedef struct packed {
        logic        is_token;
        token_kind_t kind;
        logic [7:0]  lexeme;
    } result_t;

    // What one input item leaves for the output side: one or two results.
    typedef struct packed {
        logic    has_two;
        result_t first;
        result_t second;
    } entry_t;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_LO_S    = 8'h73;
    localparam logic [7:0] CH_LO_P    = 8'h70;

    localparam logic [2:0] SET_LEN   = 3'd3;
    localparam logic [2:0] PRINT_LEN = 3'd5;
    localparam logic [2:0] COUNT_MAX = 3'd7;

    localparam result_t RESULT_NONE = '{is_token: 1'b0, kind: KIND_ID, lexeme: 8'h00};

    function automatic logic [7:0] kw_set_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h73;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_print_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h69;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic result_t make_token(input token_kind_t kind);
        result_t r;
        r.is_token = 1'b1;
        r.kind     = kind;
        r.lexeme   = 8'h00;
        return r;
    endfunction

    function automatic result_t make_char(input logic [7:0] ch);
        result_t r;
        r.is_token = 1'b0;
        r.kind     = KIND_ID;
        r.lexeme   = ch;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tlx_char_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlx_char_if
// Input channel of the lexer: one character or an end-of-input mark per item.
// ----------------------------------------------------------------------------
interface tlx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

@@ rtl/tlx_token_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlx_token_if
// Output channel of the lexer: one token or one lexeme character per item.
// ----------------------------------------------------------------------------
interface tlx_token_if;
    logic       valid;
    logic       ready;
    logic       is_token;
    logic [3:0] token_kind;
    logic [7:0] lexeme_char;
    logic       last;

    modport source (output valid, output is_token, output token_kind,
                    output lexeme_char, output last, input ready);
    modport sink   (input valid, input is_token, input token_kind,
                    input lexeme_char, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/tlx_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlx_front
// Scanner: takes one character a cycle while the queue is not full, updates the
// scan state and puts the one or two results that the character causes, if any, in one queue entry.
// ----------------------------------------------------------------------------
module tlx_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    tlx_char_if.sink           in_ch,
    input  wire logic          queue_full,
    output logic               push,
    output tlx_pkg::entry_t    push_entry
);

    tlx_pkg::scan_mode_t mode_reg, mode_next;
    logic [2:0]          count_reg, count_next;
    logic                set_ok_reg, set_ok_next;
    logic                print_ok_reg, print_ok_next;

    logic       accept;
    logic [7:0] c;
    logic       eoi;
    logic       is_letter, is_digit;

    // Letter-run update when the character extends the current word.
    logic [2:0] cnt_inc;
    logic       set_ok_add, print_ok_add;
    logic       set_hit, print_hit;

    // Handling of the character as if the scanner were idle.
    tlx_pkg::scan_mode_t idle_mode;
    logic                idle_res_v;
    tlx_pkg::result_t    idle_res;

    logic             e0_v, e1_v;
    tlx_pkg::result_t e0, e1;

    assign c         = in_ch.char_byte;
    assign eoi       = in_ch.end_of_input;
    assign in_ch.ready = !queue_full;
    assign accept    = in_ch.valid && !queue_full;

    assign is_letter = (c >= tlx_pkg::CH_LO_A && c <= tlx_pkg::CH_LO_Z)
                    || (c >= tlx_pkg::CH_UP_A && c <= tlx_pkg::CH_UP_Z);
    assign is_digit  = (c >= tlx_pkg::CH_ZERO && c <= tlx_pkg::CH_NINE);

    assign cnt_inc      = (count_reg == tlx_pkg::COUNT_MAX) ? tlx_pkg::COUNT_MAX
                                                            : count_reg + 3'd1;
    assign set_ok_add   = set_ok_reg
                       && (count_reg >= tlx_pkg::SET_LEN
                           || c == tlx_pkg::kw_set_char(count_reg));
    assign print_ok_add = print_ok_reg
                       && (count_reg >= tlx_pkg::PRINT_LEN
                           || c == tlx_pkg::kw_print_char(count_reg));
    assign set_hit      = (cnt_inc == tlx_pkg::SET_LEN) && set_ok_add;
    assign print_hit    = !set_hit && (cnt_inc == tlx_pkg::PRINT_LEN) && print_ok_add;

    always_comb
    begin
        idle_mode  = tlx_pkg::MODE_IDLE;
        idle_res_v = 1'b0;
        idle_res   = tlx_pkg::RESULT_NONE;
        if (is_letter)
        begin
            // A single letter never completes a keyword.
            idle_mode  = tlx_pkg::MODE_WORD;
            idle_res_v = 1'b1;
            idle_res   = tlx_pkg::make_char(c);
        end
        else if (is_digit)
            idle_mode = tlx_pkg::MODE_DIGITS;
        else if (c == tlx_pkg::CH_QUOTE)
            idle_mode = tlx_pkg::MODE_STRING;
        else if (c == tlx_pkg::CH_SLASH)
            idle_mode = tlx_pkg::MODE_SLASH;
        else if (c == tlx_pkg::CH_PLUS)
        begin
            idle_res_v = 1'b1;
            idle_res   = tlx_pkg::make_token(tlx_pkg::KIND_PLUS);
        end
        else if (c == tlx_pkg::CH_MINUS)
        begin
            idle_res_v = 1'b1;
            idle_res   = tlx_pkg::make_token(tlx_pkg::KIND_MINUS);
        end
        else if (c == tlx_pkg::CH_STAR)
        begin
            idle_res_v = 1'b1;
            idle_res   = tlx_pkg::make_token(tlx_pkg::KIND_STAR);
        end
        else if (c == tlx_pkg::CH_SEMI)
        begin
            idle_res_v = 1'b1;
            idle_res   = tlx_pkg::make_token(tlx_pkg::KIND_SEMI);
        end
    end

    // Next state.
    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        set_ok_next   = set_ok_reg;
        print_ok_next = print_ok_reg;
        if (accept)
        begin
            if (eoi)
            begin
                mode_next     = tlx_pkg::MODE_IDLE;
                count_next    = 3'd0;
                set_ok_next   = 1'b1;
                print_ok_next = 1'b1;
            end
            else
            begin
                // Restart from idle unless a mode below keeps its run going.
                mode_next     = idle_mode;
                count_next    = is_letter ? 3'd1 : 3'd0;
                set_ok_next   = is_letter ? (c == tlx_pkg::CH_LO_S) : 1'b1;
                print_ok_next = is_letter ? (c == tlx_pkg::CH_LO_P) : 1'b1;
                unique case (mode_reg)
                    tlx_pkg::MODE_WORD:
                    begin
                        if (is_letter)
                        begin
                            if (set_hit || print_hit)
                            begin
                                mode_next     = tlx_pkg::MODE_IDLE;
                                count_next    = 3'd0;
                                set_ok_next   = 1'b1;
                                print_ok_next = 1'b1;
                            end
                            else
                            begin
                                mode_next     = tlx_pkg::MODE_WORD;
                                count_next    = cnt_inc;
                                set_ok_next   = set_ok_add;
                                print_ok_next = print_ok_add;
                            end
                        end
                    end
                    tlx_pkg::MODE_DIGITS:
                    begin
                        if (is_digit)
                            mode_next = tlx_pkg::MODE_DIGITS;
                    end
                    tlx_pkg::MODE_STRING:
                    begin
                        if (c == tlx_pkg::CH_QUOTE || c == tlx_pkg::CH_NEWLINE)
                            mode_next = tlx_pkg::MODE_IDLE;
                        else
                            mode_next = tlx_pkg::MODE_STRING;
                        count_next    = 3'd0;
                        set_ok_next   = 1'b1;
                        print_ok_next = 1'b1;
                    end
                    tlx_pkg::MODE_SLASH:
                    begin
                        if (c == tlx_pkg::CH_SLASH)
                        begin
                            mode_next     = tlx_pkg::MODE_COMMENT;
                            count_next    = 3'd0;
                            set_ok_next   = 1'b1;
                            print_ok_next = 1'b1;
                        end
                    end
                    tlx_pkg::MODE_COMMENT:
                    begin
                        mode_next     = (c == tlx_pkg::CH_NEWLINE) ? tlx_pkg::MODE_IDLE
                                                                   : tlx_pkg::MODE_COMMENT;
                        count_next    = 3'd0;
                        set_ok_next   = 1'b1;
                        print_ok_next = 1'b1;
                    end
                    tlx_pkg::MODE_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Results of the accepted character: e0 comes out before e1.
    always_comb
    begin
        e0_v = 1'b0;
        e0   = tlx_pkg::RESULT_NONE;
        e1_v = 1'b0;
        e1   = tlx_pkg::RESULT_NONE;
        if (eoi)
        begin
            e0_v = (mode_reg == tlx_pkg::MODE_WORD) || (mode_reg == tlx_pkg::MODE_DIGITS)
                || (mode_reg == tlx_pkg::MODE_SLASH);
            if (mode_reg == tlx_pkg::MODE_WORD)
                e0 = tlx_pkg::make_token(tlx_pkg::KIND_ID);
            else if (mode_reg == tlx_pkg::MODE_DIGITS)
                e0 = tlx_pkg::make_token(tlx_pkg::KIND_INT);
            else
                e0 = tlx_pkg::make_token(tlx_pkg::KIND_SLASH);
            e1_v = 1'b1;
            e1   = tlx_pkg::make_token(tlx_pkg::KIND_DONE);
        end
        else
        begin
            e1_v = idle_res_v;
            e1   = idle_res;
            unique case (mode_reg)
                tlx_pkg::MODE_WORD:
                begin
                    if (is_letter)
                    begin
                        e0_v = 1'b1;
                        e0   = tlx_pkg::make_char(c);
                        e1_v = set_hit || print_hit;
                        e1   = tlx_pkg::make_token(set_hit ? tlx_pkg::KIND_SET
                                                           : tlx_pkg::KIND_PRINT);
                    end
                    else
                    begin
                        e0_v = 1'b1;
                        e0   = tlx_pkg::make_token(tlx_pkg::KIND_ID);
                    end
                end
                tlx_pkg::MODE_DIGITS:
                begin
                    if (is_digit)
                        e1_v = 1'b0;
                    else
                    begin
                        e0_v = 1'b1;
                        e0   = tlx_pkg::make_token(tlx_pkg::KIND_INT);
                    end
                end
                tlx_pkg::MODE_STRING:
                begin
                    e0_v = 1'b1;
                    e0   = (c == tlx_pkg::CH_QUOTE) ? tlx_pkg::make_token(tlx_pkg::KIND_STRING)
                                                    : tlx_pkg::make_char(c);
                    // A newline inside a string closes it and also emits a DONE token.
                    e1_v = (c == tlx_pkg::CH_NEWLINE);
                    e1   = tlx_pkg::make_token(tlx_pkg::KIND_DONE);
                end
                tlx_pkg::MODE_SLASH:
                begin
                    if (c == tlx_pkg::CH_SLASH)
                        e1_v = 1'b0;
                    else
                    begin
                        e0_v = 1'b1;
                        e0   = tlx_pkg::make_token(tlx_pkg::KIND_SLASH);
                    end
                end
                tlx_pkg::MODE_COMMENT:
                    e1_v = 1'b0;
                tlx_pkg::MODE_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        push_entry.has_two = e0_v && e1_v;
        push_entry.first   = e0_v ? e0 : e1;
        push_entry.second  = e1;
    end

    assign push = accept && (e0_v || e1_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= tlx_pkg::MODE_IDLE;
            count_reg    <= 3'd0;
            set_ok_reg   <= 1'b1;
            print_ok_reg <= 1'b1;
        end
        else
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            set_ok_reg   <= set_ok_next;
            print_ok_reg <= print_ok_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tlx_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlx_queue
// Short first-in first-out queue of scanner entries between the two sides.
// DEPTH must be at least 2.
// ----------------------------------------------------------------------------
module tlx_queue
#(
    parameter int DEPTH = tlx_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tlx_pkg::entry_t push_entry,
    input  wire logic            pop,
    output tlx_pkg::entry_t      head,
    output logic                 empty,
    output logic                 full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlx_pkg::entry_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tlx_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlx_back
// Output side: takes queue entries apart into single results and holds each
// one in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module tlx_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tlx_pkg::entry_t head,
    input  wire logic            empty,
    output logic                 pop,
    tlx_token_if.source          out_ch
);

    logic             valid_reg, valid_next;
    logic             second_reg, second_next;
    tlx_pkg::result_t data_reg, data_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_end;

    // The output register can take a new result when it is empty or drained now.
    assign load   = !valid_reg || out_ch.ready;
    assign at_end = !head.has_two || second_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                data_next   = second_reg ? head.second : head.first;
                last_next   = at_end;
                pop         = at_end;
                second_next = !at_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.is_token    = data_reg.is_token;
    assign out_ch.token_kind  = 4'(data_reg.kind);
    assign out_ch.lexeme_char = data_reg.lexeme;
    assign out_ch.last        = last_reg;

endmodule
`default_nettype wire

@@ rtl/token_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// token_lexer
// Streaming lexer: characters in, identifier/integer/string/operator/keyword
// tokens and lexeme characters out.
// ----------------------------------------------------------------------------
// The lexer takes one character a clock while its queue has room; each
// character is scanned in the cycle it is accepted and leaves zero, one or
// two results. Results leave through a registered output at one per clock
// while the consumer is ready, so the sustained input rate is one character a
// clock as long as characters average no more than one result each; runs of
// two-result characters (a letter that ends a keyword, an operator right after
// a word) are absorbed by the QUEUE_DEPTH-entry queue and then throttle input
// to the output rate. A character's results pass through a queue slot and then
// the output register. Each result's last flag marks the final result of its
// character; characters with no result produce nothing on the output.
// ----------------------------------------------------------------------------
module token_lexer
#(
    parameter int QUEUE_DEPTH = tlx_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tlx_char_if.sink     in_ch,
    tlx_token_if.source  out_ch
);

    logic            push;
    tlx_pkg::entry_t push_entry;
    logic            pop;
    tlx_pkg::entry_t head;
    logic            empty;
    logic            full;

    tlx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    tlx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    tlx_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire
